[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/pufm_pkg.sv]
// shared types and constants of the powered union-find mst unit
package pufm_pkg;

	localparam int NODES      = 2048;
	localparam int NODE_W     = $clog2(NODES);
	localparam int SIZE_W     = NODE_W + 1;
	localparam int COST_W     = 62;
	localparam int TOTAL_W    = 63;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 64;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef logic [NODE_W-1:0] node_t;

	// one table entry: size and powered mean something only at a root
	typedef struct packed {
		logic              pw;
		logic [SIZE_W-1:0] size;
		node_t             parent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_MERGE,
		ST_LINK,
		ST_DONE
	} seq_state_t;

	// candidate handed to the sequencer, valid marks the accept cycle
	typedef struct packed {
		logic  valid;
		logic  mode;
		node_t node_a;
		node_t node_b;
	} item_t;

	typedef struct packed {
		logic valid;
		logic taken;
	} result_t;

	typedef struct packed {
		logic   we;
		node_t  waddr;
		entry_t wdata;
		logic   re;
		node_t  raddr;
	} mem_req_t;

endpackage

[rtl/core/pufm_ram.sv]
// generic simple dual-port ram with registered read
module pufm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/pufm_seq.sv]
// find, compress and merge sequencer working on the union-find table
module pufm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  pufm_pkg::item_t    item,
	output logic               ready,
	input  logic               out_free,
	output pufm_pkg::result_t  res,
	output pufm_pkg::mem_req_t mem,
	input  pufm_pkg::entry_t   rd
);

	import pufm_pkg::*;

	seq_state_t state_q, state_d;

	node_t  clr_q;
	node_t  cur_q;
	node_t  start_q;
	logic   phase_q;
	logic   mode_q;
	node_t  nb_q;
	node_t  root_a_q;
	node_t  root_b_q;
	entry_t ent_a_q;
	entry_t ent_b_q;
	logic   taken_q;

	node_t             cur_root;
	logic              at_root;
	logic              link_ok;
	logic              a_wins;
	node_t             winner;
	node_t             child;
	entry_t            child_ent;
	logic              merged_pw;
	logic [SIZE_W-1:0] size_sum;
	logic              take;

	assign cur_root  = phase_q ? root_b_q : root_a_q;
	assign at_root   = (rd.parent == cur_q);
	assign merged_pw = ent_a_q.pw | ent_b_q.pw;
	assign link_ok   = (root_a_q != root_b_q) && !(ent_a_q.pw && ent_b_q.pw);
	assign a_wins    = (ent_a_q.size >= ent_b_q.size);
	assign winner    = a_wins ? root_a_q : root_b_q;
	assign child     = a_wins ? root_b_q : root_a_q;
	assign child_ent = a_wins ? ent_b_q : ent_a_q;
	assign size_sum  = ent_a_q.size + ent_b_q.size;
	assign take      = mode_q ? link_ok : !ent_a_q.pw;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_W'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (at_root) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (cur_q == cur_root) begin
					state_d = (!phase_q && mode_q) ? ST_WALK : ST_MERGE;
				end
			end
			ST_MERGE: begin
				state_d = (mode_q && link_ok) ? ST_LINK : ST_DONE;
			end
			ST_LINK: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		mem       = '0;
		ready     = 1'b0;
		res.valid = 1'b0;
		res.taken = taken_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem.we    = 1'b1;
				mem.waddr = clr_q;
				mem.wdata = '{pw: 1'b0, size: SIZE_W'(1), parent: clr_q};
			end
			ST_IDLE: begin
				ready     = 1'b1;
				mem.re    = item.valid;
				mem.raddr = item.node_a;
			end
			ST_WALK: begin
				// climb, or restart at the start node for the compression pass
				mem.re    = 1'b1;
				mem.raddr = at_root ? start_q : rd.parent;
			end
			ST_COMP: begin
				if (cur_q != cur_root) begin
					mem.we    = 1'b1;
					mem.waddr = cur_q;
					mem.wdata = '{pw: rd.pw, size: rd.size, parent: cur_root};
					mem.re    = 1'b1;
					mem.raddr = rd.parent;
				end else if (!phase_q && mode_q) begin
					mem.re    = 1'b1;
					mem.raddr = nb_q;
				end
			end
			ST_MERGE: begin
				if (!mode_q && !ent_a_q.pw) begin
					mem.we    = 1'b1;
					mem.waddr = root_a_q;
					mem.wdata = '{pw: 1'b1, size: ent_a_q.size, parent: root_a_q};
				end else if (mode_q && link_ok) begin
					mem.we    = 1'b1;
					mem.waddr = winner;
					mem.wdata = '{pw: merged_pw, size: size_sum, parent: winner};
				end
			end
			ST_LINK: begin
				mem.we    = 1'b1;
				mem.waddr = child;
				mem.wdata = '{pw: child_ent.pw, size: child_ent.size, parent: winner};
			end
			ST_DONE: begin
				res.valid = out_free;
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					mode_q  <= item.mode;
					nb_q    <= item.node_b;
					cur_q   <= item.node_a;
					start_q <= item.node_a;
					phase_q <= 1'b0;
				end
			end
			ST_WALK: begin
				if (at_root) begin
					if (phase_q) begin
						root_b_q <= cur_q;
						ent_b_q  <= rd;
					end else begin
						root_a_q <= cur_q;
						ent_a_q  <= rd;
					end
					cur_q <= start_q;
				end else begin
					cur_q <= rd.parent;
				end
			end
			ST_COMP: begin
				if (cur_q != cur_root) begin
					cur_q <= rd.parent;
				end else if (!phase_q && mode_q) begin
					phase_q <= 1'b1;
					cur_q   <= nb_q;
					start_q <= nb_q;
				end
			end
			ST_MERGE: begin
				taken_q <= take;
			end
			ST_CLEAR, ST_LINK, ST_DONE: begin
				taken_q <= taken_q;
			end
			default: begin
				taken_q <= taken_q;
			end
		endcase
	end

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_no_rw_same_entry, clk, arst_n, mem.we && mem.re, mem.waddr != mem.raddr, "read and write hit the same table entry")
	`ASSERT_IMPLY(a_walk_has_data, clk, arst_n, state_q == ST_WALK || state_q == ST_COMP, $past(mem.re), "walk step without a read issued")

endmodule

[rtl/core/powered_union_find_mst_unit.sv]
// top level of the powered union-find minimum spanning forest unit
// usage
//   candidates arrive on the s_ stream in ascending cost order, as the sender
//   must keep them (the block does not enforce it); s_tuser is the mode
//   (0 builds a station at node_a, 1 links node_a with node_b); every candidate
//   gives exactly one result transaction on the m_ stream: the taken flag and
//   the saturating running total after this candidate
// operation
//   one candidate is worked on at a time; a find walks the parent chain
//   in the table ram, one read per cycle, then walks it again to compress
//   the chain, whose length is at most log2 of the node count under union
//   by size; a link does this for node_a, then for node_b, before the merge
// reset
//   arst_n clears the control state and the total, then a clearing sweep
//   writes all 2048 table entries, one per cycle; s_tready stays low until
//   the sweep is done
// stall
//   the result sits in an output register; the next candidate is accepted and
//   searched while it waits, and only the final hand-off holds until m_tready
module powered_union_find_mst_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// node_a [10:0], node_b [21:11], cost [83:22], zero fill above
	input  logic [pufm_pkg::IN_DATA_W-1:0]     s_tdata,
	// mode [0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// taken [0], total_cost [63:1]
	output logic [pufm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	import pufm_pkg::*;

	item_t    item;
	result_t  res;
	mem_req_t mem;
	entry_t   rd_ent;
	logic     seq_ready;
	logic     out_free;

	logic [COST_W-1:0]     cost_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [TOTAL_W:0]      sum;
	logic [TOTAL_W-1:0]    total_nxt;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// input side: only the candidate fields go to the sequencer, cost stays here
	assign s_tready    = seq_ready;
	assign item.valid  = s_tvalid && seq_ready;
	assign item.mode   = s_tuser;
	assign item.node_a = s_tdata[NODE_W-1:0];
	assign item.node_b = s_tdata[2*NODE_W-1:NODE_W];

	// output register is free when empty or draining this cycle
	assign out_free = !m_tvalid_q || m_tready;

	// saturating accumulate, sum cannot pass 2^64 so the top bit flags overflow
	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(cost_q);
	assign total_nxt = !res.taken ? total_q
		: (sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0]);

	pufm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NODES)
	) u_table (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_ent)
	);

	pufm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.ready    (seq_ready),
		.out_free (out_free),
		.res      (res),
		.mem      (mem),
		.rd       (rd_ent)
	);

	always_ff @(posedge clk) begin
		if (item.valid) begin
			cost_q <= s_tdata[2*NODE_W+COST_W-1:2*NODE_W];
		end
		if (res.valid) begin
			m_tdata_q <= {total_nxt, res.taken};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res.valid) begin
				total_q    <= total_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "second candidate accepted while one is in flight")
	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, res.valid, !m_tvalid_q || m_tready, "result overwrote a pending output transaction")
	`ASSERT_NEXT(a_total_monotonic, clk, arst_n, 1'b1, total_q >= $past(total_q), "running total decreased")

endmodule

[test/pufm_checker.sv]
// transaction checker for the powered union-find mst unit: predicts and compares results
package pufm_tb_pkg;
	typedef enum bit {
		MODE_STATION = 1'b0,
		MODE_LINK    = 1'b1
	} cand_mode_t;
endpackage

module pufm_checker
	import pufm_pkg::*;
	import pufm_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// node_a, node_b, cost, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// taken, total_cost
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    errors,
	output int                    pending,
	output int                    candidates,
	output int                    taken_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit                 taken;
		logic [TOTAL_W-1:0] total;
	} outcome_t;

	// shadow forest
	node_t              up_link[NODES];
	logic [SIZE_W-1:0]  comp_size[NODES];
	bit                 comp_live[NODES];
	logic [TOTAL_W-1:0] spend;
	outcome_t           awaited[$];

	// root lookup, every node on the walk is pointed at the root
	function automatic node_t root_of(node_t n);
		node_t r;
		node_t nxt;
		r = n;
		while (up_link[r] != r)
			r = up_link[r];
		while (n != r) begin
			nxt = up_link[n];
			up_link[n] = r;
			n = nxt;
		end
		return r;
	endfunction

	function automatic void add_cost(logic [COST_W-1:0] c);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, spend} + (TOTAL_W + 1)'(c);
		spend = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
	endfunction

	// node indexes are 11 bits wide, so every index is in range for 2048 nodes
	function automatic bit settle(cand_mode_t mode, node_t a, node_t b,
		logic [COST_W-1:0] c);
		node_t ra;
		node_t rb;
		bit    merged_pw;
		ra = root_of(a);
		if (mode == MODE_STATION) begin
			if (comp_live[ra])
				return 1'b0;
			comp_live[ra] = 1'b1;
			add_cost(c);
			return 1'b1;
		end
		rb = root_of(b);
		if (ra == rb || (comp_live[ra] && comp_live[rb]))
			return 1'b0;
		merged_pw = comp_live[ra] | comp_live[rb];
		// ties keep the root of node_a on top
		if (comp_size[ra] >= comp_size[rb]) begin
			up_link[rb] = ra;
			comp_live[ra] = merged_pw;
			comp_size[ra] = comp_size[ra] + comp_size[rb];
		end else begin
			up_link[ra] = rb;
			comp_live[rb] = merged_pw;
			comp_size[rb] = comp_size[rb] + comp_size[ra];
		end
		add_cost(c);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got,
		logic [TOTAL_W-1:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		bit       verdict;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				up_link[i] = node_t'(i);
				comp_size[i] = SIZE_W'(1);
				comp_live[i] = 1'b0;
			end
			spend = '0;
			awaited.delete();
			errors = 0;
			pending = 0;
			candidates = 0;
			taken_cnt = 0;
		end else begin
			// result side first, a result never belongs to a candidate of the same edge
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					report_mismatch("result with nothing awaited", m_tdata[OUT_DATA_W-1:1], '0);
				end else begin
					want = awaited.pop_front();
					if (m_tdata[0] !== want.taken)
						report_mismatch("taken", TOTAL_W'(m_tdata[0]), TOTAL_W'(want.taken));
					if (m_tdata[OUT_DATA_W-1:1] !== want.total)
						report_mismatch("total_cost", m_tdata[OUT_DATA_W-1:1], want.total);
				end
			end
			if (s_tvalid && s_tready) begin
				verdict = settle(cand_mode_t'(s_tuser), s_tdata[NODE_W-1:0],
					s_tdata[2*NODE_W-1:NODE_W], s_tdata[2*NODE_W+COST_W-1:2*NODE_W]);
				want.taken = verdict;
				want.total = spend;
				awaited.insert(awaited.size(), want);
				candidates++;
				if (verdict)
					taken_cnt++;
			end
			pending = awaited.size();
		end
	end

endmodule

[test/testbench.sv]
// top of the testbench: stimulus, flow control and verdict for the powered union-find mst unit
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pufm_pkg::*;
	import pufm_tb_pkg::*;

	typedef logic [COST_W-1:0] cost_t;

	localparam int RANDOM_ITEMS = 1425;
	localparam int CALM_ITEMS   = 200;   // tail of the random part runs without idling
	localparam int HOLD_AT      = 300;   // random item at which the receiver holds off
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_AT     = 700;   // random item before which the sender drains the block
	localparam int RESERVED_LO  = 2032;  // nodes from here up stay out of the random part, for the final part
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG     = 8192;

	localparam cost_t COST_TOP  = '1;
	localparam cost_t COST_ALT1 = {31{2'b10}};
	localparam cost_t COST_ALT0 = {31{2'b01}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int errors;
	int pending;
	int candidates;
	int taken_cnt;

	// flow control knobs for the sender and the receiver, and the watchdog's idle count
	bit calm;
	bit hold_out;
	int gap_pct;
	int stall_pct;
	int idle_cycles;

	powered_union_find_mst_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pufm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.pending    (pending),
		.candidates (candidates),
		.taken_cnt  (taken_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a stretch with no transaction on either side that reaches the WATCHDOG limit ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall bursts, one long hold-off on request, steady at the end
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				// long hold lets the output register fill and back up the input
				m_tready <= 1'b0;
				hold_out = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				gap = $urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one candidate transaction; entered right after the previous handshake edge
	task automatic offer(cand_mode_t mode, node_t a, node_t b, cost_t c);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({c, b, a});
		s_tuser  <= mode;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		int    rand_sent;
		int    span;
		int    base;
		int    burst;
		int    roll;
		cost_t cost_now;
		node_t na;
		node_t nb;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		calm      = 1'b0;
		hold_out  = 1'b0;
		gap_pct   = 0;
		stall_pct = 0;
		idle_cycles = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed part on a fresh table; the first offer waits out the clearing sweep
		offer(MODE_STATION, 0, 0, 0);                  // first station at node 0, zero cost
		offer(MODE_STATION, 0, 2047, COST_TOP);        // already powered, node_b ignored
		offer(MODE_LINK, 0, 1, 5);                     // powered with unpowered, tie in size
		offer(MODE_LINK, 1, 0, COST_ALT1);             // same component
		offer(MODE_STATION, 2047, 0, 10);              // highest node
		offer(MODE_LINK, 0, 2047, COST_TOP);           // both sides powered
		offer(MODE_LINK, 2046, 2047, 12);              // tie, node_a root stays on top
		offer(MODE_LINK, 3, 4, 13);                    // two unpowered singles
		offer(MODE_LINK, 5, 3, 14);                    // smaller node_a side goes under
		offer(MODE_LINK, 3, 3, COST_ALT0);             // link of a node with itself
		offer(MODE_STATION, 5, 0, 15);                 // station through a non-root node
		offer(MODE_STATION, 4, 0, COST_ALT1);          // component already powered
		offer(MODE_LINK, 11'h555, 11'h2AA, 16);
		offer(MODE_LINK, 11'h2AA, 11'h555, COST_ALT0);
		offer(MODE_LINK, 11'h555, 0, 17);              // unpowered into powered, equal sizes
		offer(MODE_LINK, 1, 11'h2AA, COST_TOP);        // now one component
		offer(MODE_LINK, 3, 2046, 18);                 // both powered again
		offer(MODE_LINK, 6, 7, 19);
		offer(MODE_LINK, 8, 9, 20);
		offer(MODE_LINK, 6, 8, 21);
		offer(MODE_LINK, 9, 0, 22);                    // deeper chain into the powered tree

		// random part: bursts of well-formed candidates over a small window of nodes,
		// so merges build real trees, mixed with noise over every node below the reserved ones
		cost_now  = 100;
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			span  = $urandom_range(4, 64);
			base  = $urandom_range(0, RESERVED_LO - span);
			burst = $urandom_range(10, 40);
			case ($urandom_range(0, 3))
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 10; stall_pct = 10; end
				2: begin gap_pct = 35; stall_pct = 15; end
				default: begin gap_pct = 15; stall_pct = 45; end
			endcase
			for (int k = 0; k < burst && rand_sent < RANDOM_ITEMS; k++) begin
				if (rand_sent == HOLD_AT)
					hold_out = 1'b1;
				if (rand_sent == DRAIN_AT) begin
					// sender goes quiet until every result is back
					@(negedge clk);
					s_tvalid <= 1'b0;
					while (pending != 0) @(negedge clk);
				end
				calm = (rand_sent >= RANDOM_ITEMS - CALM_ITEMS);
				cost_now = cost_now + (cost_t'($urandom_range(0, 1 << 20)) << $urandom_range(0, 16));
				roll = $urandom_range(0, 99);
				na = node_t'(base + $urandom_range(0, span - 1));
				nb = node_t'(base + $urandom_range(0, span - 1));
				if (roll < 12) begin
					offer(MODE_STATION, na, nb, cost_now);
				end else if (roll < 88) begin
					offer(MODE_LINK, na, nb, cost_now);
				end else begin
					// noise: any node below the reserved ones, any mode, small cost out of order
					na = node_t'($urandom_range(0, RESERVED_LO - 1));
					nb = node_t'($urandom_range(0, RESERVED_LO - 1));
					offer(cand_mode_t'($urandom_range(0, 1)), na, nb, cost_t'($urandom));
				end
				rand_sent++;
			end
		end

		// final part on reserved nodes: huge costs drive the total into saturation
		calm = 1'b1;
		offer(MODE_STATION, node_t'(RESERVED_LO), 0, COST_TOP);
		offer(MODE_STATION, node_t'(RESERVED_LO + 1), 0, COST_TOP);
		offer(MODE_LINK, node_t'(RESERVED_LO + 2), node_t'(RESERVED_LO + 3), 1);
		offer(MODE_LINK, node_t'(RESERVED_LO), node_t'(RESERVED_LO + 1), COST_TOP);
		offer(MODE_STATION, node_t'(RESERVED_LO + 4), 0, 0);
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then leave room for any stray result; the watchdog bounds the wait
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d candidates with %0d taken, from an empty forest to a saturated total",
			candidates, taken_cnt);
		$display("flow control: random idling on both sides, one %0d cycle output hold, one full drain",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pufm_pkg.sv
rtl/core/pufm_ram.sv
rtl/core/pufm_seq.sv
rtl/core/powered_union_find_mst_unit.sv
test/pufm_checker.sv
test/testbench.sv
